FILE: sv/permtr_pkg.sv
// ----------------------------------------------------------------------------
// permtr_pkg
// Shared constants, types and tables for the symmetric tensor rotation block.
// ----------------------------------------------------------------------------
package permtr_pkg;

   // Field formats
   localparam int ANGLE_W = 18;
   localparam int AFB     = 8;     // angle fraction bits
   localparam int TFB     = 30;    // trig fraction bits
   localparam int PERM_W  = 32;

   // Internal trig formats
   localparam int Q30     = 30;
   localparam int X_W     = 30;    // radians at Q30, below pi/4
   localparam int T_W     = 31;    // Horner term, up to 2^30
   localparam int NA_W    = 30;    // Horner numerator after pre-shift
   localparam int TRIG_W  = TFB + 2;
   localparam int RM_W    = TRIG_W + 1;
   localparam int G_W     = RM_W + 1;
   localparam int TRIG_DROP = Q30 - TFB;

   // Angle reduction
   localparam int FULL_TURN = 360 << AFB;
   localparam int EIGHTH    = 45 << AFB;
   localparam int RED_W     = $clog2(FULL_TURN);
   localparam int PHI_W     = $clog2(EIGHTH + 1);

   // Degrees to radians: x = round(phi * PI_Q40 / DEG_DIV)
   localparam longint unsigned PI_Q40  = 64'h3243F6A8886;
   localparam int              DIV_SHIFT = AFB + 12;
   localparam longint unsigned DEG_DIV = 64'd45 << DIV_SHIFT;
   localparam longint unsigned RAD_Q   = PI_Q40 / DEG_DIV;
   localparam longint unsigned RAD_R   = PI_Q40 % DEG_DIV;
   localparam int Q_W   = $clog2(RAD_Q + 1);
   localparam int R_W   = $clog2(DEG_DIV);
   localparam int W_W   = PHI_W + R_W + 1;
   localparam int V_W   = W_W - DIV_SHIFT;
   localparam int K45   = V_W + 6;
   localparam longint unsigned M45 = ((64'd1 << K45) + 64'd44) / 64'd45;
   localparam int M45_W = $clog2(M45 + 1);

   // Horner divisors (2k)(2k+1) and (2k-1)(2k), k = 6 down to 1,
   // split into a power of two and an odd factor
   localparam int HORNER_N = 6;
   localparam int RECIP_K  = 36;
   localparam int RECIP_W  = 37;
   localparam int SIN_SHIFT [HORNER_N] = '{2, 1, 3, 1, 2, 1};
   localparam int SIN_HALF  [HORNER_N] = '{78, 55, 36, 21, 10, 3};
   localparam int COS_SHIFT [HORNER_N] = '{2, 1, 3, 1, 2, 1};
   localparam int COS_HALF  [HORNER_N] = '{66, 45, 28, 15, 6, 1};
   localparam logic [RECIP_W-1:0] SIN_RECIP [HORNER_N] = '{
      RECIP_W'(((64'd1 << RECIP_K) + 64'd38) / 64'd39),
      RECIP_W'(((64'd1 << RECIP_K) + 64'd54) / 64'd55),
      RECIP_W'(((64'd1 << RECIP_K) + 64'd8) / 64'd9),
      RECIP_W'(((64'd1 << RECIP_K) + 64'd20) / 64'd21),
      RECIP_W'(((64'd1 << RECIP_K) + 64'd4) / 64'd5),
      RECIP_W'(((64'd1 << RECIP_K) + 64'd2) / 64'd3)
   };
   localparam logic [RECIP_W-1:0] COS_RECIP [HORNER_N] = '{
      RECIP_W'(((64'd1 << RECIP_K) + 64'd32) / 64'd33),
      RECIP_W'(((64'd1 << RECIP_K) + 64'd44) / 64'd45),
      RECIP_W'(((64'd1 << RECIP_K) + 64'd6) / 64'd7),
      RECIP_W'(((64'd1 << RECIP_K) + 64'd14) / 64'd15),
      RECIP_W'(((64'd1 << RECIP_K) + 64'd2) / 64'd3),
      RECIP_W'(64'd1 << RECIP_K)
   };

   // Tensor accumulation widths
   localparam int LO_W  = TFB + 1 + G_W;
   localparam int HI_W  = PERM_W - TFB + 1 + G_W;
   localparam int LOS_W = LO_W + 2;
   localparam int HIS_W = HI_W + 2;
   localparam int ENT_W = ((HIS_W > LOS_W - TFB) ? HIS_W : LOS_W - TFB) + 1;

   // Pipeline
   localparam int TRIG_LAT = 19;
   localparam int PIPE_LAT = 26;
   localparam int PERM_DLY = 23;
   localparam int ENTRY_N  = 6;
   localparam int ENT_I [ENTRY_N] = '{0, 0, 0, 1, 1, 2};
   localparam int ENT_J [ENTRY_N] = '{0, 1, 2, 1, 2, 2};

   typedef struct packed {
      logic signed [TRIG_W-1:0] sin_v;
      logic signed [TRIG_W-1:0] cos_v;
   } trig_pair_type;

endpackage

FILE: sv/permtr_trig.sv
// ----------------------------------------------------------------------------
// permtr_trig
// Pipelined sine and cosine of one angle in degrees: reduction, octant fold,
// radian conversion and a six-term Horner series, 19 register stages.
// ----------------------------------------------------------------------------
module permtr_trig (
   input  logic                                     clock,
   input  logic                                     en,
   input  logic signed [permtr_pkg::ANGLE_W-1:0]   angle,
   output permtr_pkg::trig_pair_type                result
);

   localparam int SW = ((permtr_pkg::ANGLE_W > permtr_pkg::RED_W) ?
                        permtr_pkg::ANGLE_W : permtr_pkg::RED_W) + 2;
   localparam logic signed [SW-1:0] FULL_S = SW'(permtr_pkg::FULL_TURN);
   localparam int HS = 2 * permtr_pkg::HORNER_N;
   localparam int TW = permtr_pkg::T_W;
   localparam logic [TW-1:0] ONE_Q30 = TW'(1) << permtr_pkg::Q30;

   function automatic logic [TW-1:0] mul_q30(input logic [TW-1:0] a,
                                              input logic [TW-1:0] b);
      logic [2*TW-1:0] p;
      p = a * b + ((2*TW)'(1) << (permtr_pkg::Q30 - 1));
      return p[permtr_pkg::Q30+TW-1:permtr_pkg::Q30];
   endfunction

   // T1: reduce into one full turn
   logic signed [SW-1:0]              a_s, a_p1, a_p2, a_p3;
   logic [permtr_pkg::RED_W-1:0]      red_ff, red_in;

   always_comb begin
      a_s  = SW'(angle);
      a_p1 = (a_s < 0) ? a_s + FULL_S : a_s;
      a_p2 = (a_p1 < 0) ? a_p1 + FULL_S : a_p1;
      a_p3 = (a_p2 >= FULL_S) ? a_p2 - FULL_S : a_p2;
      red_in = a_p3[permtr_pkg::RED_W-1:0];
   end

   // T2: octant and fold
   logic [2:0]                        oct_in, oct2_ff, oct3_ff, oct4_ff;
   logic [permtr_pkg::RED_W-1:0]      rem_in;
   logic [permtr_pkg::PHI_W-1:0]      phi_in, phi_ff;

   always_comb begin
      oct_in = '0;
      for (int k = 1; k < 8; k++) begin
         if (red_ff >= permtr_pkg::RED_W'(k * permtr_pkg::EIGHTH)) begin
            oct_in = oct_in + 3'd1;
         end
      end
      rem_in = red_ff - permtr_pkg::RED_W'(permtr_pkg::RED_W'(oct_in) *
                                           permtr_pkg::RED_W'(permtr_pkg::EIGHTH));
      phi_in = oct_in[0] ?
               permtr_pkg::PHI_W'(permtr_pkg::RED_W'(permtr_pkg::EIGHTH) - rem_in) :
               permtr_pkg::PHI_W'(rem_in);
   end

   // T3: integer part and remainder of phi * pi / 180
   logic [permtr_pkg::PHI_W+permtr_pkg::Q_W-1:0] pq_full;
   logic [permtr_pkg::W_W-1:0]                    w_full;
   logic [permtr_pkg::X_W-1:0]                    pq_ff;
   logic [permtr_pkg::V_W-1:0]                    v_ff;

   always_comb begin
      pq_full = phi_ff * permtr_pkg::Q_W'(permtr_pkg::RAD_Q);
      w_full  = phi_ff * permtr_pkg::R_W'(permtr_pkg::RAD_R) +
                permtr_pkg::W_W'(permtr_pkg::DEG_DIV / 2);
   end

   // T4: divide the remainder by 45 through a reciprocal
   logic [permtr_pkg::V_W+permtr_pkg::M45_W-1:0] q45_full;
   logic [permtr_pkg::X_W-1:0]                    x_ff;

   assign q45_full = v_ff * permtr_pkg::M45_W'(permtr_pkg::M45);

   // T5 onward: carried values
   logic [permtr_pkg::X_W-1:0] cx_ff  [HS+1];
   logic [permtr_pkg::X_W-1:0] cx2_ff [HS+1];
   logic [2:0]                 coct_ff [HS+1];

   always_ff @(posedge clock) begin
      if (en) begin
         red_ff  <= red_in;
         oct2_ff <= oct_in;
         phi_ff  <= phi_in;
         oct3_ff <= oct2_ff;
         pq_ff   <= permtr_pkg::X_W'(pq_full);
         v_ff    <= w_full[permtr_pkg::W_W-1:permtr_pkg::DIV_SHIFT];
         oct4_ff <= oct3_ff;
         x_ff    <= pq_ff + permtr_pkg::X_W'(q45_full >> permtr_pkg::K45);
         cx_ff[0]   <= x_ff;
         cx2_ff[0]  <= permtr_pkg::X_W'(mul_q30(TW'(x_ff), TW'(x_ff)));
         coct_ff[0] <= oct4_ff;
         for (int h = 1; h <= HS; h++) begin
            cx_ff[h]   <= cx_ff[h-1];
            cx2_ff[h]  <= cx2_ff[h-1];
            coct_ff[h] <= coct_ff[h-1];
         end
      end
   end

   // Horner steps: two stages each, multiply then divide by constant
   logic [permtr_pkg::NA_W-1:0] na_s_ff [permtr_pkg::HORNER_N];
   logic [permtr_pkg::NA_W-1:0] na_c_ff [permtr_pkg::HORNER_N];
   logic [TW-1:0]               tb_s_ff [permtr_pkg::HORNER_N];
   logic [TW-1:0]               tb_c_ff [permtr_pkg::HORNER_N];

   for (genvar i = 0; i < permtr_pkg::HORNER_N; i++) begin : g_horner
      logic [TW-1:0] ts_prev, tc_prev;
      logic [permtr_pkg::NA_W+permtr_pkg::RECIP_W-1:0] qs_full, qc_full;

      if (i == 0) begin : g_first
         assign ts_prev = ONE_Q30;
         assign tc_prev = ONE_Q30;
      end else begin : g_next
         assign ts_prev = tb_s_ff[i-1];
         assign tc_prev = tb_c_ff[i-1];
      end

      assign qs_full = na_s_ff[i] * permtr_pkg::SIN_RECIP[i];
      assign qc_full = na_c_ff[i] * permtr_pkg::COS_RECIP[i];

      always_ff @(posedge clock) begin
         if (en) begin
            na_s_ff[i] <= permtr_pkg::NA_W'(
               (mul_q30(TW'(cx2_ff[2*i]), ts_prev) + TW'(permtr_pkg::SIN_HALF[i]))
               >> permtr_pkg::SIN_SHIFT[i]);
            na_c_ff[i] <= permtr_pkg::NA_W'(
               (mul_q30(TW'(cx2_ff[2*i]), tc_prev) + TW'(permtr_pkg::COS_HALF[i]))
               >> permtr_pkg::COS_SHIFT[i]);
            tb_s_ff[i] <= ONE_Q30 - TW'(qs_full >> permtr_pkg::RECIP_K);
            tb_c_ff[i] <= ONE_Q30 - TW'(qc_full >> permtr_pkg::RECIP_K);
         end
      end
   end

   // S: sine = x * series; U: round to output format and unfold
   logic [permtr_pkg::X_W-1:0]       sv_ff;
   logic [TW-1:0]                    cv_ff, sv_t, cv_t;
   logic [2:0]                       octs_ff;
   logic signed [permtr_pkg::TRIG_W-1:0] su, cu;
   permtr_pkg::trig_pair_type        res_in, res_ff;

   always_comb begin
      sv_t = TW'((TW'(sv_ff) + ((TW'(1) << permtr_pkg::TRIG_DROP) >> 1))
                 >> permtr_pkg::TRIG_DROP);
      cv_t = TW'((cv_ff + ((TW'(1) << permtr_pkg::TRIG_DROP) >> 1))
                 >> permtr_pkg::TRIG_DROP);
      if (octs_ff[0]) begin
         su = signed'(permtr_pkg::TRIG_W'(cv_t));
         cu = signed'(permtr_pkg::TRIG_W'(sv_t));
      end else begin
         su = signed'(permtr_pkg::TRIG_W'(sv_t));
         cu = signed'(permtr_pkg::TRIG_W'(cv_t));
      end
      case (octs_ff[2:1])
         2'd0: begin
            res_in.sin_v = su;
            res_in.cos_v = cu;
         end
         2'd1: begin
            res_in.sin_v = cu;
            res_in.cos_v = -su;
         end
         2'd2: begin
            res_in.sin_v = -su;
            res_in.cos_v = -cu;
         end
         default: begin
            res_in.sin_v = -cu;
            res_in.cos_v = su;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sv_ff   <= permtr_pkg::X_W'(mul_q30(TW'(cx_ff[HS]),
                                             tb_s_ff[permtr_pkg::HORNER_N-1]));
         cv_ff   <= tb_c_ff[permtr_pkg::HORNER_N-1];
         octs_ff <= coct_ff[HS];
         res_ff  <= res_in;
      end
   end

   assign result = res_ff;

endmodule

FILE: sv/permeability_tensor_rotation_3d.sv
// ----------------------------------------------------------------------------
// permeability_tensor_rotation_3d
// Rotates a diagonal permeability tensor by three angles and returns the six
// distinct entries of R * diag(max, mid, min) * R^T.
// ----------------------------------------------------------------------------
//  channel   direction   handshake            payload
//  req_      in          req_valid/req_stall  three angles, three permeabilities
//  rsp_      out         rsp_valid/rsp_stall  xx xy xz yy yz zz
//
//  One transaction per cycle while rsp_stall does not hold the output; the 19-stage
//  trig pipeline is followed by the matrix, product and accumulation stages.
//  Reset clears the valid bits of every stage; payload registers keep data.
//  An output held by rsp_stall freezes the whole pipeline and raises req_stall.
// ----------------------------------------------------------------------------
module permeability_tensor_rotation_3d (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [permtr_pkg::ANGLE_W-1:0] req_angle_one,
   input  logic signed [permtr_pkg::ANGLE_W-1:0] req_angle_two,
   input  logic signed [permtr_pkg::ANGLE_W-1:0] req_angle_three,
   input  logic [permtr_pkg::PERM_W-1:0]         req_perm_max,
   input  logic [permtr_pkg::PERM_W-1:0]         req_perm_mid,
   input  logic [permtr_pkg::PERM_W-1:0]         req_perm_min,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [permtr_pkg::PERM_W-1:0]         rsp_perm_xx,
   output logic signed [permtr_pkg::PERM_W:0]    rsp_perm_xy,
   output logic signed [permtr_pkg::PERM_W:0]    rsp_perm_xz,
   output logic [permtr_pkg::PERM_W-1:0]         rsp_perm_yy,
   output logic signed [permtr_pkg::PERM_W:0]    rsp_perm_yz,
   output logic [permtr_pkg::PERM_W-1:0]         rsp_perm_zz
);

   localparam int TW  = permtr_pkg::TRIG_W;
   localparam int RW  = permtr_pkg::RM_W;
   localparam int GW  = permtr_pkg::G_W;
   localparam int PW  = permtr_pkg::PERM_W;
   localparam int TFB = permtr_pkg::TFB;
   localparam int EW  = permtr_pkg::ENT_W;
   localparam int PW2 = 2 * RW;
   localparam logic signed [PW2-1:0] TM_HALF = PW2'(1) << (TFB - 1);
   localparam logic signed [permtr_pkg::LOS_W-1:0] LO_HALF =
      permtr_pkg::LOS_W'(1) << (TFB - 1);
   localparam logic signed [EW-1:0] PMAX_E = EW'((64'd1 << PW) - 64'd1);

   function automatic logic signed [GW-1:0] tmul(input logic signed [RW-1:0] a,
                                                  input logic signed [RW-1:0] b);
      logic signed [PW2-1:0] p;
      p = a * b + TM_HALF;
      return GW'(p >>> TFB);
   endfunction

   // Pipeline control
   logic                                en;
   logic [permtr_pkg::PIPE_LAT-1:0]     vld_ff;

   assign en        = !(vld_ff[permtr_pkg::PIPE_LAT-1] && rsp_stall);
   assign req_stall = !en;
   assign rsp_valid = vld_ff[permtr_pkg::PIPE_LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[permtr_pkg::PIPE_LAT-2:0], req_valid};
      end
   end

   // Sine and cosine of each angle
   permtr_pkg::trig_pair_type tp1, tp2, tp3;

   permtr_trig u_trig_one (.clock(clock), .en(en), .angle(req_angle_one), .result(tp1));
   permtr_trig u_trig_two (.clock(clock), .en(en), .angle(req_angle_two), .result(tp2));
   permtr_trig u_trig_three (.clock(clock), .en(en), .angle(req_angle_three),
                             .result(tp3));

   // Permeabilities travel alongside the trig pipeline
   logic [PW-1:0] perm_ff [permtr_pkg::PERM_DLY][3];

   always_ff @(posedge clock) begin
      if (en) begin
         perm_ff[0][0] <= req_perm_max;
         perm_ff[0][1] <= req_perm_mid;
         perm_ff[0][2] <= req_perm_min;
         for (int j = 1; j < permtr_pkg::PERM_DLY; j++) begin
            perm_ff[j] <= perm_ff[j-1];
         end
      end
   end

   // M1: pair products
   logic signed [TW-1:0] c1c2_ff, c1s2_ff, s1c3_ff, s1s3_ff, s1c2_ff;
   logic signed [TW-1:0] s1s2_ff, c1c3_ff, c1s3_ff, c2s3_ff, c2c3_ff;
   logic signed [TW-1:0] s2_ff, s3_ff, c3_ff;
   // M2: triple products
   logic signed [TW-1:0] t1_ff, t2_ff, t3_ff, t4_ff;
   logic signed [TW-1:0] m2_c1c2_ff, m2_s1c3_ff, m2_s1s3_ff, m2_s1c2_ff;
   logic signed [TW-1:0] m2_c1c3_ff, m2_c1s3_ff, m2_c2s3_ff, m2_c2c3_ff, m2_s2_ff;
   // M3: rotation matrix
   logic signed [RW-1:0] rm_ff [3][3];
   // G: entry weights
   logic signed [GW-1:0] g_ff [permtr_pkg::ENTRY_N][3];
   // P1, P2: weighted sums
   logic signed [permtr_pkg::LO_W-1:0]  lo_ff  [permtr_pkg::ENTRY_N][3];
   logic signed [permtr_pkg::HI_W-1:0]  hi_ff  [permtr_pkg::ENTRY_N][3];
   logic signed [permtr_pkg::LOS_W-1:0] los_ff [permtr_pkg::ENTRY_N];
   logic signed [permtr_pkg::HIS_W-1:0] his_ff [permtr_pkg::ENTRY_N];

   always_ff @(posedge clock) begin
      if (en) begin
         c1c2_ff <= TW'(tmul(RW'(tp1.cos_v), RW'(tp2.cos_v)));
         c1s2_ff <= TW'(tmul(RW'(tp1.cos_v), RW'(tp2.sin_v)));
         s1c3_ff <= TW'(tmul(RW'(tp1.sin_v), RW'(tp3.cos_v)));
         s1s3_ff <= TW'(tmul(RW'(tp1.sin_v), RW'(tp3.sin_v)));
         s1c2_ff <= TW'(tmul(RW'(tp1.sin_v), RW'(tp2.cos_v)));
         s1s2_ff <= TW'(tmul(RW'(tp1.sin_v), RW'(tp2.sin_v)));
         c1c3_ff <= TW'(tmul(RW'(tp1.cos_v), RW'(tp3.cos_v)));
         c1s3_ff <= TW'(tmul(RW'(tp1.cos_v), RW'(tp3.sin_v)));
         c2s3_ff <= TW'(tmul(RW'(tp2.cos_v), RW'(tp3.sin_v)));
         c2c3_ff <= TW'(tmul(RW'(tp2.cos_v), RW'(tp3.cos_v)));
         s2_ff   <= tp2.sin_v;
         s3_ff   <= tp3.sin_v;
         c3_ff   <= tp3.cos_v;

         t1_ff      <= TW'(tmul(RW'(c1s2_ff), RW'(s3_ff)));
         t2_ff      <= TW'(tmul(RW'(c1s2_ff), RW'(c3_ff)));
         t3_ff      <= TW'(tmul(RW'(s1s2_ff), RW'(s3_ff)));
         t4_ff      <= TW'(tmul(RW'(s1s2_ff), RW'(c3_ff)));
         m2_c1c2_ff <= c1c2_ff;
         m2_s1c3_ff <= s1c3_ff;
         m2_s1s3_ff <= s1s3_ff;
         m2_s1c2_ff <= s1c2_ff;
         m2_c1c3_ff <= c1c3_ff;
         m2_c1s3_ff <= c1s3_ff;
         m2_c2s3_ff <= c2s3_ff;
         m2_c2c3_ff <= c2c3_ff;
         m2_s2_ff   <= s2_ff;

         rm_ff[0][0] <= RW'(m2_c1c2_ff);
         rm_ff[0][1] <= -RW'(t1_ff) - RW'(m2_s1c3_ff);
         rm_ff[0][2] <= -RW'(t2_ff) + RW'(m2_s1s3_ff);
         rm_ff[1][0] <= RW'(m2_s1c2_ff);
         rm_ff[1][1] <= -RW'(t3_ff) + RW'(m2_c1c3_ff);
         rm_ff[1][2] <= -RW'(t4_ff) - RW'(m2_c1s3_ff);
         rm_ff[2][0] <= RW'(m2_s2_ff);
         rm_ff[2][1] <= RW'(m2_c2s3_ff);
         rm_ff[2][2] <= RW'(m2_c2c3_ff);

         for (int e = 0; e < permtr_pkg::ENTRY_N; e++) begin
            for (int k = 0; k < 3; k++) begin
               g_ff[e][k] <= tmul(rm_ff[permtr_pkg::ENT_I[e]][k],
                                  rm_ff[permtr_pkg::ENT_J[e]][k]);
               lo_ff[e][k] <= signed'({1'b0, perm_ff[permtr_pkg::PERM_DLY-1][k][TFB-1:0]})
                              * g_ff[e][k];
               hi_ff[e][k] <= signed'({1'b0, perm_ff[permtr_pkg::PERM_DLY-1][k][PW-1:TFB]})
                              * g_ff[e][k];
            end
            los_ff[e] <= permtr_pkg::LOS_W'(lo_ff[e][0]) + permtr_pkg::LOS_W'(lo_ff[e][1]) +
                         permtr_pkg::LOS_W'(lo_ff[e][2]);
            his_ff[e] <= permtr_pkg::HIS_W'(hi_ff[e][0]) + permtr_pkg::HIS_W'(hi_ff[e][1]) +
                         permtr_pkg::HIS_W'(hi_ff[e][2]);
         end
      end
   end

   // P3: round once, saturate
   logic signed [EW-1:0]  ent_v [permtr_pkg::ENTRY_N];
   logic [PW-1:0]         diag_in [permtr_pkg::ENTRY_N];
   logic signed [PW:0]    off_in  [permtr_pkg::ENTRY_N];

   always_comb begin
      for (int e = 0; e < permtr_pkg::ENTRY_N; e++) begin
         ent_v[e] = EW'(his_ff[e]) + EW'((los_ff[e] + LO_HALF) >>> TFB);
         if (ent_v[e] < 0) begin
            diag_in[e] = '0;
         end else if (ent_v[e] > PMAX_E) begin
            diag_in[e] = '1;
         end else begin
            diag_in[e] = ent_v[e][PW-1:0];
         end
         if (ent_v[e] > PMAX_E) begin
            off_in[e] = (PW+1)'(PMAX_E);
         end else if (ent_v[e] < -PMAX_E) begin
            off_in[e] = -((PW+1)'(PMAX_E));
         end else begin
            off_in[e] = ent_v[e][PW:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_perm_xx <= diag_in[0];
         rsp_perm_xy <= off_in[1];
         rsp_perm_xz <= off_in[2];
         rsp_perm_yy <= diag_in[3];
         rsp_perm_yz <= off_in[4];
         rsp_perm_zz <= diag_in[5];
      end
   end

endmodule

FILE: sv/permtr_chk.sv
// ----------------------------------------------------------------------------
// permtr_chk
// Port-level checks for the tensor rotation block, bound to the top level.
// ----------------------------------------------------------------------------
module permtr_chk (
   input logic                                   clock,
   input logic                                   reset,
   input logic                                   req_valid,
   input logic                                   req_stall,
   input logic signed [permtr_pkg::ANGLE_W-1:0] req_angle_one,
   input logic signed [permtr_pkg::ANGLE_W-1:0] req_angle_two,
   input logic signed [permtr_pkg::ANGLE_W-1:0] req_angle_three,
   input logic [permtr_pkg::PERM_W-1:0]         req_perm_max,
   input logic [permtr_pkg::PERM_W-1:0]         req_perm_mid,
   input logic [permtr_pkg::PERM_W-1:0]         req_perm_min,
   input logic                                   rsp_valid,
   input logic                                   rsp_stall,
   input logic [permtr_pkg::PERM_W-1:0]         rsp_perm_xx,
   input logic signed [permtr_pkg::PERM_W:0]    rsp_perm_xy,
   input logic signed [permtr_pkg::PERM_W:0]    rsp_perm_xz,
   input logic [permtr_pkg::PERM_W-1:0]         rsp_perm_yy,
   input logic signed [permtr_pkg::PERM_W:0]    rsp_perm_yz,
   input logic [permtr_pkg::PERM_W-1:0]         rsp_perm_zz
);

   localparam logic [permtr_pkg::PERM_W:0] NEG_FULL = {1'b1, permtr_pkg::PERM_W'(0)};

   // Held transaction stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("rsp_valid dropped while stalled");

   // Held transaction keeps its xx, xy and zz payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_perm_xx) && $stable(rsp_perm_xy) &&
                                 $stable(rsp_perm_zz))
      else $error("rsp payload changed while stalled");

   // Input backpressure only comes from a blocked output
   a_req_stall: assert property (@(posedge clock) disable iff (reset)
      req_stall == (rsp_valid && rsp_stall))
      else $error("req_stall without a blocked output");

   // Reset empties the pipeline
   a_reset_clear: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("rsp_valid right after reset");

   // Off-diagonal saturation is symmetric: minus full scale never appears
   a_off_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_perm_xy != NEG_FULL) && (rsp_perm_xz != NEG_FULL) &&
                    (rsp_perm_yz != NEG_FULL))
      else $error("off-diagonal entry outside saturation range");

endmodule

bind permeability_tensor_rotation_3d permtr_chk u_permtr_chk (.*);
